[hw/rtl/assert_macros.svh]
// assertion macros for the rtl of the message window
// expects clk and rst in the scope of each use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising edge outside reset
`define RMW_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// implication checked on every rising edge outside reset
`define RMW_ASSERT_IMP(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) else $error(msg);

`endif

[hw/rtl/rmw_pkg.sv]
// types, codes and helpers of the reliable message window
// no dependencies
package rmw_pkg;

  localparam int MAX_RESULTS = 16;
  localparam logic [15:0] RESEND_RESET = 16'd300;

  typedef enum logic [1:0] {
    ACT_ADD  = 2'd0,
    ACT_RECV = 2'd1,
    ACT_TICK = 2'd2
  } action_t;

  typedef enum logic [1:0] {
    OP_ADD  = 2'd0,
    OP_RECV = 2'd1,
    OP_TICK = 2'd2,
    OP_NONE = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    KIND_DELIVER  = 3'd0,
    KIND_TRANSMIT = 3'd1,
    KIND_ACCEPT   = 3'd2,
    KIND_REFUSE   = 3'd3,
    KIND_NOTHING  = 3'd4
  } kind_t;

  typedef struct packed {
    op_t         op;
    logic [31:0] seq;
    logic [31:0] ack;
    logic [15:0] tag;
    logic [31:0] now;
  } item_t;

  typedef struct packed {
    kind_t       kind;
    logic [31:0] seq;
    logic [31:0] ack;
    logic [15:0] tag;
    logic        last;
  } result_t;

  function automatic logic serial_ahead(input logic [31:0] a, input logic [31:0] b);
    logic [31:0] d;
    d = a - b;
    return (d != 32'd0) && !d[31];
  endfunction

endpackage

[hw/rtl/rmw_front.sv]
// front part: decodes input beats and holds them in a two-entry queue
// depends on rmw_pkg
module rmw_front (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  output logic           full,
  input  logic [1:0]     action,
  input  logic [31:0]    pkt_seq,
  input  logic [31:0]    pkt_ack,
  input  logic [15:0]    payload_tag,
  input  logic [31:0]    now_ms,
  output logic           item_valid,
  output rmw_pkg::item_t item,
  input  logic           item_pop
);
  import rmw_pkg::*;

  item_t      q [2];
  logic       wp, rp;
  logic [1:0] cnt;
  item_t      dec;
  logic       wr, rd;

  always_comb begin
    dec.seq = pkt_seq;
    dec.ack = pkt_ack;
    dec.tag = payload_tag;
    dec.now = now_ms;
    unique case (action)
      ACT_ADD:  dec.op = OP_ADD;
      ACT_RECV: dec.op = OP_RECV;
      ACT_TICK: dec.op = OP_TICK;
      default:  dec.op = OP_NONE;
    endcase
  end

  assign full       = (cnt == 2'd2);
  assign item_valid = (cnt != 2'd0);
  assign item       = q[rp];
  assign wr         = push && !full;
  assign rd         = item_pop && item_valid;

  always_ff @(posedge clk) begin
    if (wr) begin
      q[wp] <= dec;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= 1'b0;
      rp  <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (wr) wp <= !wp;
      if (rd) rp <= !rp;
      cnt <= cnt + {1'b0, wr} - {1'b0, rd};
    end
  end

endmodule

[hw/rtl/rmw_outq.sv]
// result queue: two entries between the engine and the result port
// depends on rmw_pkg
module rmw_outq (
  input  logic             clk,
  input  logic             rst,
  input  logic             res_push,
  input  rmw_pkg::result_t res,
  output logic             res_full,
  output logic             empty,
  input  logic             pop,
  output rmw_pkg::result_t head
);
  import rmw_pkg::*;

  result_t    q [2];
  logic       wp, rp;
  logic [1:0] cnt;
  logic       wr, rd;

  assign res_full = (cnt == 2'd2);
  assign empty    = (cnt == 2'd0);
  assign head     = q[rp];
  assign wr       = res_push && !res_full;
  assign rd       = pop && !empty;

  always_ff @(posedge clk) begin
    if (wr) begin
      q[wp] <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= 1'b0;
      rp  <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (wr) wp <= !wp;
      if (rd) rp <= !rp;
      cnt <= cnt + {1'b0, wr} - {1'b0, rd};
    end
  end

endmodule

[hw/rtl/rmw_engine.sv]
// back part: send window, reorder window, drain and resend sequencer
// depends on rmw_pkg and assert_macros.svh
module rmw_engine #(
  parameter int SEND_DEPTH  = 16,
  parameter int RECV_WINDOW = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_write,
  input  logic [15:0]      cfg_data,
  input  logic             item_valid,
  input  rmw_pkg::item_t   item,
  output logic             item_pop,
  output logic             res_push,
  output rmw_pkg::result_t res,
  input  logic             res_full
);
  import rmw_pkg::*;
  `include "assert_macros.svh"

  localparam int SW  = $clog2(SEND_DEPTH);
  localparam int RW  = $clog2(RECV_WINDOW);
  localparam int CAP = (SEND_DEPTH < MAX_RESULTS) ? SEND_DEPTH : MAX_RESULTS;
  localparam logic [SW:0]   SDEP = (SW + 1)'(SEND_DEPTH);
  localparam logic [RW:0]   RDEP = (RW + 1)'(RECV_WINDOW);
  localparam logic [SW-1:0] SLAST = SW'(SEND_DEPTH - 1);
  localparam logic [RW-1:0] RLAST = RW'(RECV_WINDOW - 1);

  typedef enum logic [9:0] {
    ST_IDLE        = 10'b0000000001,
    ST_ADD         = 10'b0000000010,
    ST_RECV        = 10'b0000000100,
    ST_DRAIN_RD    = 10'b0000001000,
    ST_DRAIN_EMIT  = 10'b0000010000,
    ST_TICK_PURGE  = 10'b0000100000,
    ST_TICK_CHECK  = 10'b0001000000,
    ST_RESEND_RD   = 10'b0010000000,
    ST_RESEND_EMIT = 10'b0100000000,
    ST_NOTHING     = 10'b1000000000
  } state_t;

  state_t      state;
  item_t       cur;
  logic [15:0] interval;
  logic [31:0] next_send_seq, acked_upto, next_expected, last_send_time, oldest_unacked;
  logic [SW-1:0] wptr, optr, rptr;
  logic [RW-1:0] eptr;
  logic [RECV_WINDOW-1:0] held_valid;
  logic [4:0]  n, idx, cnt;

  logic [15:0] send_mem [SEND_DEPTH];
  logic [15:0] tag_mem  [RECV_WINDOW];
  logic [31:0] ack_mem  [RECV_WINDOW];
  logic [15:0] rd_stag, rd_htag;
  logic [31:0] rd_hack;

  logic [31:0] count, diff, step, off, elapsed;
  logic        win_full, fire, drain_more, store;
  logic [RW:0] slot_sum;
  logic [RW-1:0] slot, eptr_inc;
  logic [SW:0] psum;
  logic [SW-1:0] rptr_inc, wptr_inc;

  assign count    = next_send_seq - oldest_unacked;
  assign diff     = acked_upto - oldest_unacked;
  assign step     = (diff > count) ? count : diff;
  assign win_full = (count >= 32'(CAP));
  assign off      = cur.seq - next_expected;
  assign slot_sum = {1'b0, eptr} + off[RW:0];
  assign slot     = (slot_sum >= RDEP) ? RW'(slot_sum - RDEP) : slot_sum[RW-1:0];
  assign store    = (off < 32'(RECV_WINDOW)) && !held_valid[slot];
  assign eptr_inc = (eptr == RLAST) ? '0 : eptr + 1'b1;
  assign rptr_inc = (rptr == SLAST) ? '0 : rptr + 1'b1;
  assign wptr_inc = (wptr == SLAST) ? '0 : wptr + 1'b1;
  assign psum     = {1'b0, optr} + step[SW:0];
  assign elapsed  = cur.now - last_send_time;
  assign drain_more = (n != 5'd15) && held_valid[eptr_inc];
  assign item_pop = (state == ST_IDLE) && item_valid;
  assign fire     = res_push && !res_full;

  always_comb begin
    res_push = 1'b0;
    res      = '0;
    res.kind = KIND_NOTHING;
    unique case (state)
      ST_ADD: begin
        res_push = 1'b1;
        res.tag  = cur.tag;
        res.last = 1'b1;
        if (win_full) begin
          res.kind = KIND_REFUSE;
        end else begin
          res.kind = KIND_ACCEPT;
          res.seq  = next_send_seq;
        end
      end
      ST_DRAIN_EMIT: begin
        res_push = 1'b1;
        res.kind = KIND_DELIVER;
        res.seq  = next_expected;
        res.tag  = rd_htag;
        res.last = !drain_more;
      end
      ST_RESEND_EMIT: begin
        res_push = 1'b1;
        res.kind = KIND_TRANSMIT;
        res.seq  = oldest_unacked + {27'd0, idx};
        res.ack  = next_expected;
        res.tag  = rd_stag;
        res.last = (idx + 5'd1 == cnt);
      end
      ST_NOTHING: begin
        res_push = 1'b1;
        res.last = 1'b1;
      end
      default: res_push = 1'b0;
    endcase
  end

  // storage, no reset
  always_ff @(posedge clk) begin
    if (state == ST_ADD && !win_full && fire) begin
      send_mem[wptr] <= cur.tag;
    end
    if (state == ST_RECV && store) begin
      tag_mem[slot] <= cur.tag;
      ack_mem[slot] <= cur.ack;
    end
    if (state == ST_RESEND_RD) begin
      rd_stag <= send_mem[rptr];
    end
    if (state == ST_DRAIN_RD) begin
      rd_htag <= tag_mem[eptr];
      rd_hack <= ack_mem[eptr];
    end
    if (item_pop) begin
      cur <= item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      interval       <= RESEND_RESET;
      next_send_seq  <= '0;
      acked_upto     <= '0;
      next_expected  <= '0;
      last_send_time <= '0;
      oldest_unacked <= '0;
      wptr           <= '0;
      optr           <= '0;
      rptr           <= '0;
      eptr           <= '0;
      held_valid     <= '0;
      n              <= '0;
      idx            <= '0;
      cnt            <= '0;
    end else begin
      if (cfg_write) interval <= cfg_data;
      unique case (state)
        ST_IDLE: begin
          if (item_valid) begin
            unique case (item.op)
              OP_ADD:  state <= ST_ADD;
              OP_RECV: state <= ST_RECV;
              OP_TICK: state <= ST_TICK_PURGE;
              default: state <= ST_NOTHING;
            endcase
          end
        end
        ST_ADD: begin
          if (fire) begin
            if (!win_full) begin
              next_send_seq <= next_send_seq + 32'd1;
              wptr          <= wptr_inc;
            end
            state <= ST_IDLE;
          end
        end
        ST_RECV: begin
          if (store) held_valid[slot] <= 1'b1;
          n     <= '0;
          state <= ST_DRAIN_RD;
        end
        ST_DRAIN_RD: begin
          state <= held_valid[eptr] ? ST_DRAIN_EMIT : ST_NOTHING;
        end
        ST_DRAIN_EMIT: begin
          if (fire) begin
            if (serial_ahead(rd_hack, acked_upto)) acked_upto <= rd_hack;
            held_valid[eptr] <= 1'b0;
            next_expected    <= next_expected + 32'd1;
            eptr             <= eptr_inc;
            n                <= n + 5'd1;
            state            <= drain_more ? ST_DRAIN_RD : ST_IDLE;
          end
        end
        ST_TICK_PURGE: begin
          if (diff != 32'd0 && !diff[31]) begin
            oldest_unacked <= oldest_unacked + step;
            optr <= (psum >= SDEP) ? SW'(psum - SDEP) : psum[SW-1:0];
          end
          state <= ST_TICK_CHECK;
        end
        ST_TICK_CHECK: begin
          if (elapsed > {16'd0, interval}) begin
            last_send_time <= cur.now;
            cnt            <= count[4:0];
            idx            <= '0;
            rptr           <= optr;
            state          <= (count == 32'd0) ? ST_NOTHING : ST_RESEND_RD;
          end else begin
            state <= ST_NOTHING;
          end
        end
        ST_RESEND_RD: begin
          state <= ST_RESEND_EMIT;
        end
        ST_RESEND_EMIT: begin
          if (fire) begin
            idx   <= idx + 5'd1;
            rptr  <= rptr_inc;
            state <= res.last ? ST_IDLE : ST_RESEND_RD;
          end
        end
        ST_NOTHING: begin
          if (fire) state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  `RMW_ASSERT(a_send_window, (next_send_seq - oldest_unacked) <= 32'(CAP), "send window overrun")
  `RMW_ASSERT_IMP(a_deliver_held, state == ST_DRAIN_EMIT, held_valid[eptr], "deliver of empty slot")
  `RMW_ASSERT_IMP(a_pop_idle, item_pop, state == ST_IDLE, "item taken while busy")

endmodule

[hw/rtl/reliable_message_window.sv]
// top level of the reliable message window
// depends on rmw_pkg, rmw_front, rmw_engine and rmw_outq
//
// input channel: an item (action, pkt_seq, pkt_ack, payload_tag, now_ms) is
// taken on a rising edge with push high and full low; a two-beat queue holds
// items while the engine is busy.
// result channel: the oldest result sits on kind/out_seq/out_ack/out_tag/last
// while empty is low and leaves on a rising edge with pop high. last marks
// the final result of an item.
// cfg_write loads resend_interval from cfg_data; the user must write it only
// while idle, which the block itself does not enforce. an add or an unknown
// action gives one result; a packet gives one result per delivered entry, or
// a single nothing result if none is delivered; a tick gives one result per
// resent entry, up to 16 of them, or a single nothing result. the
// engine handles one item at a time and each delivered or resent entry
// passes through a memory read state and then an emit state.
// reset clears all counters, the reorder valid bits and both queues, and sets
// resend_interval to 300. a stalled receiver fills the result queue, then
// holds the engine, then fills the input queue and raises full.
module reliable_message_window #(
  parameter int SEND_DEPTH  = 16,
  parameter int RECV_WINDOW = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [1:0]  action,
  input  logic [31:0] pkt_seq,
  input  logic [31:0] pkt_ack,
  input  logic [15:0] payload_tag,
  input  logic [31:0] now_ms,
  input  logic        cfg_write,
  input  logic [15:0] cfg_data,
  output logic        empty,
  input  logic        pop,
  output logic [2:0]  kind,
  output logic [31:0] out_seq,
  output logic [31:0] out_ack,
  output logic [15:0] out_tag,
  output logic        last
);
  import rmw_pkg::*;

  item_t   item;
  logic    item_valid, item_pop;
  result_t res, head;
  logic    res_push, res_full;

  rmw_front u_front (
    .clk, .rst, .push, .full, .action, .pkt_seq, .pkt_ack, .payload_tag, .now_ms,
    .item_valid, .item, .item_pop
  );

  rmw_engine #(.SEND_DEPTH(SEND_DEPTH), .RECV_WINDOW(RECV_WINDOW)) u_engine (
    .clk, .rst, .cfg_write, .cfg_data, .item_valid, .item, .item_pop,
    .res_push, .res, .res_full
  );

  rmw_outq u_outq (
    .clk, .rst, .res_push, .res, .res_full, .empty, .pop, .head
  );

  assign kind    = head.kind;
  assign out_seq = head.seq;
  assign out_ack = head.ack;
  assign out_tag = head.tag;
  assign last    = head.last;

endmodule
